>>> src/clf_pkg.sv
// package for the crlf line framer: sizes, character codes and control types
package clf_pkg;

  localparam int unsigned MaxLine = 64;
  localparam int unsigned CntW    = $clog2(MaxLine);
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 6;

  localparam logic [ByteW-1:0] CharCr = 8'h0D;
  localparam logic [ByteW-1:0] CharLf = 8'h0A;

  typedef struct packed {
    logic store;
    logic set_cr;
    logic clear;
    logic rd_clr;
    logic rd_inc;
    logic load_out;
  } clf_cmd_t;

  typedef struct packed {
    logic cr_pending;
    logic is_cr;
    logic is_lf;
    logic rd_last;
    logic out_free;
  } clf_stat_t;

endpackage

>>> src/clf_ctrl.sv
// controller for the crlf line framer: collect and emit sequencing
module clf_ctrl import clf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  output logic      rx_ready_o,
  input  clf_stat_t stat_i,
  output clf_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StPush
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    rx_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          if (stat_i.cr_pending) begin
            if (stat_i.is_lf) begin
              cmd_o.rd_clr = 1'b1;
              state_d      = StFetch;
            end else begin
              cmd_o.clear = 1'b1;
            end
          end else if (stat_i.is_cr) begin
            cmd_o.set_cr = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      StFetch: begin
        state_d = StPush;
      end
      StPush: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.rd_last) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            cmd_o.rd_inc = 1'b1;
            state_d      = StFetch;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/clf_dp.sv
// datapath for the crlf line framer: line store, counters and output register
module clf_dp import clf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] rx_byte_i,
  input  clf_cmd_t         cmd_i,
  output clf_stat_t        stat_o,
  output logic             line_valid_o,
  input  logic             line_ready_i,
  output logic [ByteW-1:0] line_byte_o,
  output logic [LenW-1:0]  line_length_o,
  output logic             last_byte_o
);

  logic [ByteW-1:0] mem_q [MaxLine];
  logic [ByteW-1:0] rd_data_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             cr_q, cr_d;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_last_q;
  logic             count_zero;
  logic [CntW:0]    rd_next;

  assign count_zero = (count_q == '0);
  assign rd_next    = {1'b0, rd_idx_q} + {{CntW{1'b0}}, 1'b1};

  assign stat_o.cr_pending = cr_q;
  assign stat_o.is_cr      = (rx_byte_i == CharCr);
  assign stat_o.is_lf      = (rx_byte_i == CharLf);
  assign stat_o.rd_last    = count_zero || (rd_next == {1'b0, count_q});
  assign stat_o.out_free   = !out_valid_q || line_ready_i;

  always_comb begin
    count_d  = count_q;
    cr_d     = cr_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.store) begin
      if (count_q == CntW'(MaxLine - 1)) begin
        count_d = '0;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.set_cr) begin
      cr_d = 1'b1;
    end
    if (cmd_i.rd_clr) begin
      cr_d     = 1'b0;
      rd_idx_d = '0;
    end
    if (cmd_i.rd_inc) begin
      rd_idx_d = rd_next[CntW-1:0];
    end
    if (cmd_i.clear) begin
      count_d = '0;
      cr_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cr_q        <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cr_q     <= cr_d;
      rd_idx_q <= rd_idx_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (line_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[count_q] <= rx_byte_i;
    end
    rd_data_q <= mem_q[rd_idx_q];
    if (cmd_i.load_out) begin
      out_byte_q <= count_zero ? '0 : rd_data_q;
      out_len_q  <= LenW'(count_q);
      out_last_q <= stat_o.rd_last;
    end
  end

  assign line_valid_o  = out_valid_q;
  assign line_byte_o   = out_byte_q;
  assign line_length_o = out_len_q;
  assign last_byte_o   = out_last_q;

endmodule

>>> src/crlf_line_framer.sv
// top level of the crlf line framer
//
//  channel | direction | handshake                  | payload
//  rx      | in        | rx_valid_i / rx_ready_o     | rx_byte_i
//  line    | out       | line_valid_o / line_ready_i | line_byte_o, line_length_o, last_byte_o
//
// a received byte is taken in the cycle it is offered while the framer is collecting
// a completed line is emitted item by item: a fetch state for the registered store read, then a push state
// rx_ready_o stays low from the lf until the last item of the line is in the output register
// a full output register stalls emission, and so the collection of the next line until its last item is loaded
// reset clears the count, cr flag, read index and output valid; the line store needs no clearing
module crlf_line_framer import clf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             line_valid_o,
  input  logic             line_ready_i,
  output logic [ByteW-1:0] line_byte_o,
  output logic [LenW-1:0]  line_length_o,
  output logic             last_byte_o
);

  clf_cmd_t  cmd;
  clf_stat_t stat;

  clf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .line_valid_o  (line_valid_o),
    .line_ready_i  (line_ready_i),
    .line_byte_o   (line_byte_o),
    .line_length_o (line_length_o),
    .last_byte_o   (last_byte_o)
  );

`ifndef ASSERT_OFF
  a_empty_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_valid_o && line_length_o == '0) |-> (line_byte_o == '0 && last_byte_o))
    else $error("empty line item malformed");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.store, cmd.set_cr, cmd.rd_clr, cmd.load_out}) <= 1)
    else $error("conflicting datapath commands");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && line_valid_o) |-> line_ready_i)
    else $error("output item overwritten");
`endif

endmodule

>>> bench/crlf_line_checker.sv
`timescale 1ns / 1ps
// checker for the crlf line framer: predicts line items from received bytes and compares them
module crlf_line_checker import clf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic             rx_ready_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             line_valid_i,
  input  logic             line_ready_i,
  input  logic [ByteW-1:0] line_byte_i,
  input  logic [LenW-1:0]  line_length_i,
  input  logic             last_byte_i,
  output int               fail_cnt_o,
  output int               items_due_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic             last;
  } line_item_t;

  line_item_t       line_items_due[$];
  line_item_t       want;
  logic [ByteW-1:0] held_bytes [MaxLine];
  int               held_cnt;
  logic             cr_seen;

  initial begin
    fail_cnt_o  = 0;
    items_due_o = 0;
  end

  function automatic void frame_rx_byte(input logic [ByteW-1:0] ch);
    line_item_t it;
    int         k;
    if (cr_seen) begin
      if (ch == CharLf) begin
        if (held_cnt == 0) begin
          it = '{data: '0, len: '0, last: 1'b1};
          line_items_due.push_back(it);
        end else begin
          for (k = 0; k < held_cnt; k++) begin
            it.data = held_bytes[CntW'(k)];
            it.len  = held_cnt[LenW-1:0];
            it.last = (k == held_cnt - 1);
            line_items_due.push_back(it);
          end
        end
      end
      held_cnt = 0;
      cr_seen  = 1'b0;
    end else if (ch == CharCr) begin
      cr_seen = 1'b1;
    end else begin
      held_bytes[CntW'(held_cnt)] = ch;
      held_cnt++;
      // a line may hold at most MaxLine-1 bytes
      if (held_cnt > MaxLine - 1) begin
        held_cnt = 0;
        cr_seen  = 1'b0;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_items_due.delete();
      held_cnt = 0;
      cr_seen  = 1'b0;
    end else begin
      // results are checked before the byte of this edge is predicted
      if (line_valid_i && line_ready_i) begin
        if (line_items_due.size() == 0) begin
          $error("line item with none expected: line_byte %0h line_length %0d last_byte %0b",
                 line_byte_i, line_length_i, last_byte_i);
          fail_cnt_o++;
        end else begin
          want = line_items_due.pop_front();
          if (line_byte_i !== want.data) begin
            $error("line_byte: expected %0h, got %0h", want.data, line_byte_i);
            fail_cnt_o++;
          end
          if (line_length_i !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, line_length_i);
            fail_cnt_o++;
          end
          if (last_byte_i !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte_i);
            fail_cnt_o++;
          end
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        frame_rx_byte(rx_byte_i);
      end
    end
    items_due_o = line_items_due.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// testbench top for the crlf line framer: clock, reset, byte stimulus, receiver and verdict
module tb import clf_pkg::*; ();

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 200;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             rx_valid_i   = 1'b0;
  logic             rx_ready_o;
  logic [ByteW-1:0] rx_byte_i    = '0;
  logic             line_valid_o;
  logic             line_ready_i = 1'b0;
  logic [ByteW-1:0] line_byte_o;
  logic [LenW-1:0]  line_length_o;
  logic             last_byte_o;

  int fail_cnt;
  int items_due;
  int cycle_cnt      = 0;
  int rx_sent        = 0;
  int rx_idle_pct    = 0;
  int line_stall_pct = 0;
  int hold_reqs      = 0;

  crlf_line_framer u_top (
    .clk_i,
    .rst_ni,
    .rx_valid_i,
    .rx_ready_o,
    .rx_byte_i,
    .line_valid_o,
    .line_ready_i,
    .line_byte_o,
    .line_length_o,
    .last_byte_o
  );

  crlf_line_checker u_checker (
    .clk_i,
    .rst_ni,
    .rx_valid_i,
    .rx_ready_i    (rx_ready_o),
    .rx_byte_i,
    .line_valid_i  (line_valid_o),
    .line_ready_i,
    .line_byte_i   (line_byte_o),
    .line_length_i (line_length_o),
    .last_byte_i   (last_byte_o),
    .fail_cnt_o    (fail_cnt),
    .items_due_o   (items_due)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** crlf_line_framer: FAILED **");
    $finish;
  end

  // receiver with random stalls and a long hold-off when one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        line_ready_i <= 1'b0;
      end else begin
        line_ready_i <= ($urandom_range(0, 99) >= line_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= ByteW'($urandom);
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    rx_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] text_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b == CharCr);
    return b;
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) send_byte(text_byte());
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  task automatic drain_lines();
    rx_valid_i <= 1'b0;
    @(negedge clk_i);
    while (items_due != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_items);
    int start;
    int pick;
    int len;
    logic [ByteW-1:0] b;
    rx_idle_pct    = idle;
    line_stall_pct = stall;
    start          = rx_sent;
    while (rx_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 99);
      len  = (len < 10) ? 0 : (len < 95) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      if (pick < 70) begin
        send_line(len);
      end else if (pick < 85) begin
        // cr followed by something other than lf
        for (int i = 0; i < len; i++) send_byte(text_byte());
        send_byte(CharCr);
        if ($urandom_range(0, 99) < 30) begin
          send_byte(CharCr);
        end else begin
          do b = ByteW'($urandom_range(0, 255)); while (b == CharLf);
          send_byte(b);
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty line, single bytes at both extremes, two-byte line
    send_line(0);
    send_byte(8'h00); send_byte(CharCr); send_byte(CharLf);
    send_byte(8'hFF); send_byte(CharCr); send_byte(CharLf);
    send_byte(8'h55); send_byte(8'hAA); send_byte(CharCr); send_byte(CharLf);
    // cr then a plain byte, then cr then cr, then a bare cr with nothing stored
    send_byte(8'h41); send_byte(CharCr); send_byte(8'h42);
    send_byte(8'h43); send_byte(CharCr); send_byte(CharCr);
    send_byte(CharCr); send_byte(8'h41);
    // lf on its own is stored as text
    send_byte(CharLf); send_byte(CharCr); send_byte(CharLf);

    run_phase(0, 0, 10);
    run_phase(73, 0, 10);
    drain_lines();
    run_phase(0, 73, 10);

    // longest line under a long receiver hold-off, sender keeps offering
    rx_idle_pct = 0;
    hold_reqs++;
    send_line(MaxLine - 1);
    send_line(3);
    // overlong line: the first MaxLine bytes are dropped and the bytes after them start a fresh line
    send_line(MaxLine + 1);

    run_phase(32, 32, 10);

    rx_valid_i     <= 1'b0;
    line_stall_pct = 0;
    @(negedge clk_i);
    while (items_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_cnt == 0 && items_due == 0) begin
      $display("** crlf_line_framer: PASSED **");
    end else begin
      $display("** crlf_line_framer: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
src/clf_pkg.sv
src/clf_ctrl.sv
src/clf_dp.sv
src/crlf_line_framer.sv
bench/crlf_line_checker.sv
bench/tb.sv
